/* rtl/icpa_pkg.sv */
`timescale 1ns / 1ps

package icpa_pkg;

    // Field widths
    localparam int PIN_W   = 3;
    localparam int TIME_W  = 16;
    localparam int COUNT_W = 8;
    localparam int PORT_W  = 8;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE1_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE2_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE3_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_GATED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_EDGE    = 3'd5;

    // Edge modes and edge codes {old, new}
    localparam logic [MODE_W-1:0] EDGE_OFF     = 2'b00;
    localparam logic [MODE_W-1:0] EDGE_RISING  = 2'b01;
    localparam logic [MODE_W-1:0] EDGE_FALLING = 2'b10;
    localparam logic [MODE_W-1:0] EDGE_ANY     = 2'b11;

    // Capture channel codes
    localparam logic [1:0] CH_NONE     = 2'd0;
    localparam logic [1:0] CH_CAPTURE1 = 2'd1;
    localparam logic [1:0] CH_CAPTURE2 = 2'd2;
    localparam logic [1:0] CH_CAPTURE3 = 2'd3;

    // Special pins
    localparam logic [PIN_W-1:0] PIN_CAPTURE3 = 3'd0;
    localparam logic [PIN_W-1:0] PIN_CAPTURE2 = 3'd1;
    localparam logic [PIN_W-1:0] PIN_CAPTURE1 = 3'd2;
    localparam logic [PIN_W-1:0] PIN_PULSE    = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] capture1_mode;
        logic [MODE_W-1:0] capture2_mode;
        logic [MODE_W-1:0] capture3_mode;
        logic              pulse_enable;
        logic              pulse_gated;
        logic              pulse_edge;
    } cfg_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_number;
        logic              level;
        logic [TIME_W-1:0] timer_count;
    } item_t;

    typedef struct packed {
        logic [1:0]         capture_channel;
        logic [TIME_W-1:0]  captured_time;
        logic               pulse_seen;
        logic               pulse_overflow;
        logic [COUNT_W-1:0] pulse_total;
        logic [PORT_W-1:0]  port_levels;
    } result_t;

endpackage

/* rtl/input_capture_pulse_accumulator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_pin_number, s_level, s_timer_count
// m_        out        m_valid / m_ready    m_capture_channel .. m_port_levels
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat per cycle sustained while results are taken; an input beat passes
// the input register, then edge logic into the result register.
// Synchronous active-low reset clears pin levels, pulse counter and config.
// A stalled result holds the result register; the input register still takes
// one more beat, after which s_ready drops until the result drains.
// Config writes are always taken (cfg_ready is high out of reset).

module input_capture_pulse_accumulator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [icpa_pkg::PIN_W-1:0]          s_pin_number,
    input  logic                                s_level,
    input  logic [icpa_pkg::TIME_W-1:0]         s_timer_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_capture_channel,
    output logic [icpa_pkg::TIME_W-1:0]         m_captured_time,
    output logic                                m_pulse_seen,
    output logic                                m_pulse_overflow,
    output logic [icpa_pkg::COUNT_W-1:0]        m_pulse_total,
    output logic [icpa_pkg::PORT_W-1:0]         m_port_levels,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [icpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [icpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import icpa_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;

    icpa_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the held item forward when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{pin_number: s_pin_number, level: s_level,
                             timer_count: s_timer_count};
        end
    end

    icpa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_capture_channel = out_reg.capture_channel;
    assign m_captured_time   = out_reg.captured_time;
    assign m_pulse_seen      = out_reg.pulse_seen;
    assign m_pulse_overflow  = out_reg.pulse_overflow;
    assign m_pulse_total     = out_reg.pulse_total;
    assign m_port_levels     = out_reg.port_levels;

`ifndef SYNTHESIS
    // A beat with no capture reports a zero time
    a_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_capture_channel == CH_NONE)) |-> (m_captured_time == '0))
        else $error("captured time nonzero without capture");

    // Overflow comes only with a counted pulse and a wrapped counter
    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pulse_overflow) |-> (m_pulse_seen && (m_pulse_total == '0)))
        else $error("overflow without wrap");

    // Input stall only when both stages are full and the result is stalled
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with free space");

    // A stalled result keeps its pulse total
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pulse_total)))
        else $error("stalled result changed");
`endif

endmodule

/* rtl/icpa_cfg_regs.sv */
`timescale 1ns / 1ps

module icpa_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [icpa_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [icpa_pkg::CFG_DATA_W-1:0]  wr_data,
    output icpa_pkg::cfg_t                   cfg
);
    import icpa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; ignore indexes past the list
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_CAPTURE1_MODE: cfg_next.capture1_mode = wr_data;
                CFG_CAPTURE2_MODE: cfg_next.capture2_mode = wr_data;
                CFG_CAPTURE3_MODE: cfg_next.capture3_mode = wr_data;
                CFG_PULSE_ENABLE:  cfg_next.pulse_enable  = wr_data[0];
                CFG_PULSE_GATED:   cfg_next.pulse_gated   = wr_data[0];
                CFG_PULSE_EDGE:    cfg_next.pulse_edge    = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/icpa_core.sv */
`timescale 1ns / 1ps

module icpa_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  icpa_pkg::cfg_t    cfg,
    input  icpa_pkg::item_t   item,
    output icpa_pkg::result_t result
);
    import icpa_pkg::*;

    logic [PORT_W-1:0]  pin_state_reg;
    logic [PORT_W-1:0]  pin_state_next;
    logic [COUNT_W-1:0] pulse_count_reg;
    logic [COUNT_W-1:0] pulse_count_next;

    logic              old_level;
    logic [1:0]        edge_code;
    logic [MODE_W-1:0] mode;
    logic [1:0]        channel;
    logic              is_edge;
    logic              fire;
    logic              pulse;

    // Edge code and selected channel mode
    always_comb begin
        old_level = pin_state_reg[item.pin_number];
        edge_code = {old_level, item.level};
        is_edge   = (edge_code == EDGE_RISING) || (edge_code == EDGE_FALLING);
        unique case (item.pin_number)
            PIN_CAPTURE3: begin
                mode    = cfg.capture3_mode;
                channel = CH_CAPTURE3;
            end
            PIN_CAPTURE2: begin
                mode    = cfg.capture2_mode;
                channel = CH_CAPTURE2;
            end
            PIN_CAPTURE1: begin
                mode    = cfg.capture1_mode;
                channel = CH_CAPTURE1;
            end
            default: begin
                mode    = EDGE_OFF;
                channel = CH_NONE;
            end
        endcase
        fire = (mode != EDGE_OFF) && is_edge && ((mode == edge_code) || (mode == EDGE_ANY));
        pulse = (item.pin_number == PIN_PULSE) && cfg.pulse_enable && !cfg.pulse_gated
                && is_edge && (cfg.pulse_edge != old_level);
    end

    // Update pin levels and the pulse count; pins 3 to 6 hold
    always_comb begin
        pin_state_next = pin_state_reg;
        if ((item.pin_number <= PIN_CAPTURE1) || (item.pin_number == PIN_PULSE)) begin
            pin_state_next[item.pin_number] = item.level;
        end
        pulse_count_next = pulse ? pulse_count_reg + COUNT_W'(1) : pulse_count_reg;
    end

    // Build the result beat
    always_comb begin
        result.capture_channel = fire ? channel : CH_NONE;
        result.captured_time   = fire ? item.timer_count : '0;
        result.pulse_seen      = pulse;
        result.pulse_overflow  = pulse && (pulse_count_next == '0);
        result.pulse_total     = pulse_count_next;
        result.port_levels     = pin_state_next;
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_state_reg   <= '0;
            pulse_count_reg <= '0;
        end else if (advance) begin
            pin_state_reg   <= pin_state_next;
            pulse_count_reg <= pulse_count_next;
        end
    end

endmodule

/* verif/input_capture_pulse_accumulator_tb.sv */
`timescale 1ns / 1ps

module input_capture_pulse_accumulator_tb;
    import icpa_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 4;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    // Plain port pins with no capture or pulse function
    localparam logic [PIN_W-1:0] PIN_PLAIN_LO = 3'd3;
    localparam logic [PIN_W-1:0] PIN_PLAIN_HI = 3'd6;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [PIN_W-1:0]      s_pin_number;
    logic                  s_level;
    logic [TIME_W-1:0]     s_timer_count;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_capture_channel;
    logic [TIME_W-1:0]     m_captured_time;
    logic                  m_pulse_seen;
    logic                  m_pulse_overflow;
    logic [COUNT_W-1:0]    m_pulse_total;
    logic [PORT_W-1:0]     m_port_levels;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block: register file, pin levels, pulse count
    cfg_t                  shadow_cfg;
    logic [PORT_W-1:0]     exp_pins;
    logic [COUNT_W-1:0]    exp_pulses;
    result_t               pending_reports[$];

    bit src_gaps;
    bit sink_stalls;
    int error_count;
    int cycle_count;

    input_capture_pulse_accumulator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pin_number      (s_pin_number),
        .s_level           (s_level),
        .s_timer_count     (s_timer_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_capture_channel (m_capture_channel),
        .m_captured_time   (m_captured_time),
        .m_pulse_seen      (m_pulse_seen),
        .m_pulse_overflow  (m_pulse_overflow),
        .m_pulse_total     (m_pulse_total),
        .m_port_levels     (m_port_levels),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Work out the report for one pin event and advance the shadow state
    function automatic result_t capture_and_count(input item_t ev);
        result_t    rpt;
        logic       old_lvl;
        logic [1:0] code;
        logic [1:0] mode;
        logic [1:0] chan;
        rpt     = '0;
        old_lvl = exp_pins[ev.pin_number];
        code    = {old_lvl, ev.level};
        if (ev.pin_number == PIN_CAPTURE1 || ev.pin_number == PIN_CAPTURE2 ||
            ev.pin_number == PIN_CAPTURE3) begin
            case (ev.pin_number)
                PIN_CAPTURE3: begin
                    chan = CH_CAPTURE3;
                    mode = shadow_cfg.capture3_mode;
                end
                PIN_CAPTURE2: begin
                    chan = CH_CAPTURE2;
                    mode = shadow_cfg.capture2_mode;
                end
                default: begin
                    chan = CH_CAPTURE1;
                    mode = shadow_cfg.capture1_mode;
                end
            endcase
            // Only a real transition can fire, and only on a matching mode
            if ((code == EDGE_RISING || code == EDGE_FALLING) &&
                (mode == code || mode == EDGE_ANY)) begin
                rpt.capture_channel = chan;
                rpt.captured_time   = ev.timer_count;
            end
            exp_pins[ev.pin_number] = ev.level;
        end else if (ev.pin_number == PIN_PULSE) begin
            exp_pins[PIN_PULSE] = ev.level;
            // Edge select high counts rising (old level low), low counts falling
            if (shadow_cfg.pulse_enable && !shadow_cfg.pulse_gated &&
                old_lvl != ev.level && shadow_cfg.pulse_edge != old_lvl) begin
                exp_pulses         = exp_pulses + 1'b1;
                rpt.pulse_seen     = 1'b1;
                rpt.pulse_overflow = (exp_pulses == '0);
            end
        end
        rpt.pulse_total = exp_pulses;
        rpt.port_levels = exp_pins;
        return rpt;
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CAPTURE1_MODE: shadow_cfg.capture1_mode = val;
            CFG_CAPTURE2_MODE: shadow_cfg.capture2_mode = val;
            CFG_CAPTURE3_MODE: shadow_cfg.capture3_mode = val;
            CFG_PULSE_ENABLE:  shadow_cfg.pulse_enable  = val[0];
            CFG_PULSE_GATED:   shadow_cfg.pulse_gated   = val[0];
            CFG_PULSE_EDGE:    shadow_cfg.pulse_edge    = val[0];
            default: ;
        endcase
    endfunction

    // Drop valid and hold until every report is back, then let the pipe settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the whole register map while idle, optionally poking unmapped indexes
    task automatic write_registers(input cfg_t setting, input bit poke_unmapped);
        logic [CFG_IDX_W-1:0]  idx_q[$];
        logic [CFG_DATA_W-1:0] val_q[$];
        wait_drained();
        idx_q = '{CFG_CAPTURE1_MODE, CFG_CAPTURE2_MODE, CFG_CAPTURE3_MODE,
                  CFG_PULSE_ENABLE, CFG_PULSE_GATED, CFG_PULSE_EDGE};
        // Upper data bit of the one-bit registers is don't-care; randomize it
        val_q = '{setting.capture1_mode, setting.capture2_mode, setting.capture3_mode,
                  {1'($urandom_range(0, 1)), setting.pulse_enable},
                  {1'($urandom_range(0, 1)), setting.pulse_gated},
                  {1'($urandom_range(0, 1)), setting.pulse_edge}};
        if (poke_unmapped) begin
            idx_q.push_back(CFG_UNMAPPED_LO);
            val_q.push_back(2'($urandom_range(0, 3)));
            idx_q.push_back(CFG_UNMAPPED_HI);
            val_q.push_back(2'($urandom_range(0, 3)));
        end
        foreach (idx_q[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_q[i];
            cfg_data  <= val_q[i];
            do @(posedge aclk); while (!cfg_ready);
            store_register(idx_q[i], val_q[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Send one pin event beat and queue its expected report
    task automatic drive_pin(input logic [PIN_W-1:0] pin, input logic lvl,
                             input logic [TIME_W-1:0] tcnt);
        item_t ev;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pin_number  <= pin;
        s_level       <= lvl;
        s_timer_count <= tcnt;
        do @(posedge aclk); while (!s_ready);
        ev.pin_number  = pin;
        ev.level       = lvl;
        ev.timer_count = tcnt;
        pending_reports.push_back(capture_and_count(ev));
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return TIME_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Favor the capture and pulse pins, and favor real transitions
    task automatic drive_random_event();
        logic [PIN_W-1:0] pin;
        logic             lvl;
        case ($urandom_range(0, 7))
            0, 1:    pin = PIN_W'($urandom_range(0, 7));
            2:       pin = PIN_CAPTURE1;
            3:       pin = PIN_CAPTURE2;
            4:       pin = PIN_CAPTURE3;
            default: pin = PIN_PULSE;
        endcase
        lvl = ($urandom_range(0, 2) != 0) ? ~exp_pins[pin] : 1'($urandom_range(0, 1));
        drive_pin(pin, lvl, pick_time());
    endtask

    function automatic cfg_t random_setting();
        cfg_t setting;
        setting.capture1_mode = MODE_W'($urandom_range(0, 3));
        setting.capture2_mode = MODE_W'($urandom_range(0, 3));
        setting.capture3_mode = MODE_W'($urandom_range(0, 3));
        setting.pulse_enable  = ($urandom_range(0, 3) != 0);
        setting.pulse_gated   = ($urandom_range(0, 3) == 0);
        setting.pulse_edge    = 1'($urandom_range(0, 1));
        return setting;
    endfunction

    task automatic run_phase(input cfg_t setting, input int n_items, input bit gaps,
                             input bit stalls, input bit pause_midway);
        write_registers(setting, 1'b0);
        src_gaps    = gaps;
        sink_stalls = stalls;
        for (int i = 0; i < n_items; i++) begin
            if (pause_midway && i == n_items / 2) wait_drained();
            drive_random_event();
        end
    endtask

    // Out of reset every capture is off and the accumulator is disabled
    task automatic test_reset_state();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        drive_pin(PIN_CAPTURE1, 1'b1, '1);
        drive_pin(PIN_CAPTURE2, 1'b1, '1);
        drive_pin(PIN_CAPTURE3, 1'b1, '1);
        drive_pin(PIN_PULSE, 1'b1, '1);
        drive_pin(PIN_PLAIN_LO, 1'b1, '1);
        drive_pin(PIN_PLAIN_HI, 1'b1, '0);
        drive_pin(PIN_CAPTURE1, 1'b0, '0);
        drive_pin(PIN_CAPTURE2, 1'b0, '0);
        drive_pin(PIN_CAPTURE3, 1'b0, '0);
        drive_pin(PIN_PULSE, 1'b0, '0);
    endtask

    // Rising, falling and any-edge captures, plus repeated levels that must not fire
    task automatic test_capture_edges();
        cfg_t setting;
        setting = '0;
        setting.capture1_mode = EDGE_RISING;
        setting.capture2_mode = EDGE_FALLING;
        setting.capture3_mode = EDGE_ANY;
        write_registers(setting, 1'b1);
        drive_pin(PIN_CAPTURE1, 1'b1, '1);
        drive_pin(PIN_CAPTURE1, 1'b1, 16'h1234);
        drive_pin(PIN_CAPTURE1, 1'b0, 16'h5678);
        drive_pin(PIN_CAPTURE2, 1'b1, 16'h9abc);
        drive_pin(PIN_CAPTURE2, 1'b0, '0);
        drive_pin(PIN_CAPTURE2, 1'b0, '1);
        drive_pin(PIN_CAPTURE3, 1'b1, 16'hdef0);
        drive_pin(PIN_CAPTURE3, 1'b0, 16'h8001);
    endtask

    // Rising and falling edge select, then gated mode suppressing the count
    task automatic test_pulse_modes();
        cfg_t setting;
        setting = '0;
        setting.pulse_enable = 1'b1;
        setting.pulse_edge   = 1'b1;
        write_registers(setting, 1'b1);
        drive_pin(PIN_PULSE, 1'b1, 16'h0001);
        drive_pin(PIN_PULSE, 1'b0, 16'h0002);
        drive_pin(PIN_PULSE, 1'b0, 16'h0003);
        setting.pulse_edge = 1'b0;
        write_registers(setting, 1'b0);
        drive_pin(PIN_PULSE, 1'b1, 16'h0004);
        drive_pin(PIN_PULSE, 1'b0, 16'h0005);
        setting.pulse_gated = 1'b1;
        write_registers(setting, 1'b0);
        drive_pin(PIN_PULSE, 1'b1, 16'h0006);
        drive_pin(PIN_PULSE, 1'b0, 16'h0007);
    endtask

    // Toggle pin 7 long enough to wrap the 8-bit counter at least once
    task automatic test_pulse_wrap();
        cfg_t setting;
        setting = random_setting();
        setting.pulse_enable = 1'b1;
        setting.pulse_gated  = 1'b0;
        write_registers(setting, 1'b1);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        for (int i = 0; i < 540; i++) begin
            drive_pin(PIN_PULSE, ~exp_pins[PIN_PULSE], pick_time());
            if (i % 12 == 0) drive_random_event();
        end
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++) begin
            run_phase(random_setting(), 200, p != 1, p != 2, p == 3);
        end
    endtask

    task automatic test_extreme_settings();
        cfg_t setting;
        setting = '0;
        run_phase(setting, 150, 1'b1, 1'b1, 1'b0);
        setting = '1;
        run_phase(setting, 150, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_back_to_back();
        cfg_t setting;
        setting = random_setting();
        setting.capture1_mode = EDGE_ANY;
        setting.pulse_enable  = 1'b1;
        setting.pulse_gated   = 1'b0;
        run_phase(setting, 200, 1'b0, 1'b0, 1'b0);
    endtask

    // Result sink: random stall bursts while enabled
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // Compare each report beat against the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report beat with nothing expected: channel %0d, levels %02h",
                       m_capture_channel, m_port_levels);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_capture_channel !== want.capture_channel) begin
                    $error("capture_channel: expected %0d, actual %0d",
                           want.capture_channel, m_capture_channel);
                    error_count++;
                end
                if (m_captured_time !== want.captured_time) begin
                    $error("captured_time: expected %04h, actual %04h",
                           want.captured_time, m_captured_time);
                    error_count++;
                end
                if (m_pulse_seen !== want.pulse_seen) begin
                    $error("pulse_seen: expected %0b, actual %0b",
                           want.pulse_seen, m_pulse_seen);
                    error_count++;
                end
                if (m_pulse_overflow !== want.pulse_overflow) begin
                    $error("pulse_overflow: expected %0b, actual %0b",
                           want.pulse_overflow, m_pulse_overflow);
                    error_count++;
                end
                if (m_pulse_total !== want.pulse_total) begin
                    $error("pulse_total: expected %0d, actual %0d",
                           want.pulse_total, m_pulse_total);
                    error_count++;
                end
                if (m_port_levels !== want.port_levels) begin
                    $error("port_levels: expected %02h, actual %02h",
                           want.port_levels, m_port_levels);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_pin_number  = '0;
        s_level       = 1'b0;
        s_timer_count = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        shadow_cfg    = '0;
        exp_pins      = '0;
        exp_pulses    = '0;
        src_gaps      = 1'b0;
        sink_stalls   = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_capture_edges();
        test_pulse_modes();
        test_pulse_wrap();
        test_random_settings();
        test_extreme_settings();
        test_back_to_back();

        wait_drained();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* input_capture_pulse_accumulator.f */
rtl/icpa_pkg.sv
rtl/icpa_cfg_regs.sv
rtl/icpa_core.sv
rtl/input_capture_pulse_accumulator.sv
verif/input_capture_pulse_accumulator_tb.sv
